/* rtl/olp_pkg.sv */
// shared types and byte codes for the outline line parser
`default_nettype none

package olp_pkg;

  localparam int BYTE_W        = 8;
  localparam int SPAN_W        = 25;
  localparam int DEPTH_FIELD_W = 8;
  // widest offset arithmetic the parser can need (32-bit offsets plus two)
  localparam int SPAN_EXT_W    = 34;
  localparam int DEPTH_EXT_W   = 16;

  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_DONE   = 8'h79;
  localparam logic [BYTE_W-1:0] CH_HIDE   = 8'h68;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } olp_item_t;

  typedef struct packed {
    logic [SPAN_W-1:0]        span_start;
    logic [SPAN_W-1:0]        span_end;
    logic [DEPTH_FIELD_W-1:0] indent_depth;
    logic                     done_mark;
    logic                     open_mark;
    logic                     placeholder_mark;
  } olp_rec_t;

endpackage

`default_nettype wire

/* rtl/olp_if.sv */
// handshake channel interfaces for input bytes and line records
`default_nettype none

interface olp_in_if;
  logic                           valid;
  logic                           ready;
  logic [olp_pkg::BYTE_W-1:0]     text_byte;
  logic                           final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface olp_out_if;
  logic                              valid;
  logic                              ready;
  logic [olp_pkg::SPAN_W-1:0]        span_start;
  logic [olp_pkg::SPAN_W-1:0]        span_end;
  logic [olp_pkg::DEPTH_FIELD_W-1:0] indent_depth;
  logic                              done_mark;
  logic                              open_mark;
  logic                              placeholder_mark;

  modport source (output valid, output span_start, output span_end, output indent_depth,
                  output done_mark, output open_mark, output placeholder_mark,
                  input ready);
  modport sink   (input valid, input span_start, input span_end, input indent_depth,
                  input done_mark, input open_mark, input placeholder_mark,
                  output ready);
endinterface

`default_nettype wire

/* rtl/olp_in_stage.sv */
// input register holding one byte word until the parser takes it
`default_nettype none

module olp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire olp_pkg::olp_item_t in_item,
  output logic                    in_ready,
  input  wire logic               step_en,
  output logic                    held_valid,
  output olp_pkg::olp_item_t      held_item
);
  import olp_pkg::*;

  logic      held_valid_r, held_valid_nxt;
  olp_item_t held_item_r;
  logic      take;

  assign in_ready = rst_n && (!held_valid_r || step_en);
  assign take     = in_valid && in_ready;

  always_comb begin
    held_valid_nxt = held_valid_r;
    if (take) begin
      held_valid_nxt = 1'b1;
    end else if (step_en) begin
      held_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item_r <= in_item;
    end
  end

  assign held_valid = held_valid_r;
  assign held_item  = held_item_r;

endmodule

`default_nettype wire

/* rtl/olp_parse.sv */
// per-line parse state and record forming for one byte per step
`default_nettype none

module olp_parse #(
  parameter int OFFSET_BITS = 24,
  parameter int DEPTH_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire olp_pkg::olp_item_t item,
  output logic                    rec_valid,
  output olp_pkg::olp_rec_t       rec
);
  import olp_pkg::*;

  localparam int XW = OFFSET_BITS + 2;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic                   blank_r, blank_nxt;
  logic                   inbr_r, inbr_nxt;
  logic                   brdone_r, brdone_nxt;
  logic                   mk_done_r, mk_done_nxt;
  logic                   mk_open_r, mk_open_nxt;
  logic                   mk_ph_r, mk_ph_nxt;
  logic                   mk_hide_r, mk_hide_nxt;
  logic                   seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0] first_r, first_nxt;
  logic [OFFSET_BITS-1:0] last_r, last_nxt;

  logic [BYTE_W-1:0]      ch;
  logic                   fin;
  logic                   is_text;
  logic                   seen_a;
  logic [OFFSET_BITS-1:0] first_a, last_a;
  logic                   line_end;
  logic [XW-1:0]          end_ofs;
  logic [XW-1:0]          s_x, e_x;
  logic [SPAN_EXT_W-1:0]  s_ext, e_ext;
  logic [DEPTH_EXT_W-1:0] depth_ext;

  assign ch  = item.text_byte;
  assign fin = item.final_byte;

  // cr counts as text for trimming, so only space and newline are blank
  assign is_text = (ch != CH_SPACE) && (ch != CH_LF);
  assign seen_a  = seen_r || is_text;
  assign first_a = (!seen_r && is_text) ? pos_r : first_r;
  assign last_a  = is_text ? pos_r : last_r;

  always_comb begin
    pos_nxt     = pos_r;
    depth_nxt   = depth_r;
    blank_nxt   = blank_r;
    inbr_nxt    = inbr_r;
    brdone_nxt  = brdone_r;
    mk_done_nxt = mk_done_r;
    mk_open_nxt = mk_open_r;
    mk_ph_nxt   = mk_ph_r;
    mk_hide_nxt = mk_hide_r;
    seen_nxt    = seen_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    line_end    = 1'b0;

    if (step_en) begin
      seen_nxt  = seen_a;
      first_nxt = first_a;
      last_nxt  = last_a;

      if (ch == CH_CR) begin
        // skipped
      end else if (ch == CH_LBRACK && !brdone_r) begin
        inbr_nxt  = 1'b1;
        blank_nxt = 1'b0;
        mk_ph_nxt = 1'b1;
      end else if (ch == CH_RBRACK && inbr_r) begin
        inbr_nxt   = 1'b0;
        brdone_nxt = 1'b1;
        if (!mk_hide_r) begin
          mk_open_nxt = 1'b1;
        end
        // span restarts after the bracket group
        seen_nxt = 1'b0;
      end else if (inbr_r) begin
        if (ch == CH_DONE) begin
          mk_done_nxt = 1'b1;
        end
        if (ch == CH_HIDE) begin
          mk_hide_nxt = 1'b1;
        end
      end else if (ch == CH_LF || fin) begin
        line_end = 1'b1;
      end else if (ch != CH_SPACE) begin
        blank_nxt = 1'b0;
      end else if (blank_r) begin
        if (depth_r != {DEPTH_BITS{1'b1}}) begin
          depth_nxt = depth_r + DEPTH_BITS'(1);
        end
      end

      if (line_end || fin) begin
        depth_nxt   = '0;
        blank_nxt   = 1'b1;
        inbr_nxt    = 1'b0;
        brdone_nxt  = 1'b0;
        mk_done_nxt = 1'b0;
        mk_open_nxt = 1'b0;
        mk_ph_nxt   = 1'b0;
        mk_hide_nxt = 1'b0;
        seen_nxt    = 1'b0;
      end

      if (fin) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + OFFSET_BITS'(1);
      end
    end
  end

  // span arithmetic, then cut to the record field width
  assign end_ofs   = XW'(pos_r) + (fin ? XW'(1) : XW'(0));
  assign s_x       = seen_a ? XW'(first_a) : end_ofs;
  assign e_x       = seen_a ? (XW'(last_a) + XW'(1)) : (end_ofs + XW'(1));
  assign s_ext     = SPAN_EXT_W'(s_x);
  assign e_ext     = SPAN_EXT_W'(e_x);
  assign depth_ext = DEPTH_EXT_W'(depth_r);

  assign rec_valid            = line_end && !blank_r;
  assign rec.span_start       = s_ext[SPAN_W-1:0];
  assign rec.span_end         = e_ext[SPAN_W-1:0];
  assign rec.indent_depth     = depth_ext[DEPTH_FIELD_W-1:0];
  assign rec.done_mark        = mk_done_r;
  assign rec.open_mark        = mk_open_r || !brdone_r;
  assign rec.placeholder_mark = mk_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      depth_r   <= '0;
      blank_r   <= 1'b1;
      inbr_r    <= 1'b0;
      brdone_r  <= 1'b0;
      mk_done_r <= 1'b0;
      mk_open_r <= 1'b0;
      mk_ph_r   <= 1'b0;
      mk_hide_r <= 1'b0;
      seen_r    <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      depth_r   <= depth_nxt;
      blank_r   <= blank_nxt;
      inbr_r    <= inbr_nxt;
      brdone_r  <= brdone_nxt;
      mk_done_r <= mk_done_nxt;
      mk_open_r <= mk_open_nxt;
      mk_ph_r   <= mk_ph_nxt;
      mk_hide_r <= mk_hide_nxt;
      seen_r    <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

endmodule

`default_nettype wire

/* rtl/olp_out_stage.sv */
// result register that holds a line record until the sink takes it
`default_nettype none

module olp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire olp_pkg::olp_rec_t rec_in,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output olp_pkg::olp_rec_t      rec_out,
  output logic                   free
);
  import olp_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  olp_rec_t rec_r;

  assign free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_in;
    end
  end

  assign out_valid = out_valid_r;
  assign rec_out   = rec_r;

endmodule

`default_nettype wire

/* rtl/outline_line_parser_unit.sv */
// outline line parser: one byte word per cycle in, one record per non-blank line out
// stages: two register stages, the input register and the result register; a record is
//   loaded into the result register by the parse step that takes the byte word ending its line
// throughput: one byte word per cycle; the parse step advances whenever the result
//   register is empty or being read in the same cycle
// reset: synchronous active-low rst_n clears both valid flags, the position and depth counters and the line flags
`default_nettype none

module outline_line_parser_unit #(
  parameter int OFFSET_BITS = 24,
  parameter int DEPTH_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  olp_in_if.sink    in_ch,
  olp_out_if.source out_ch
);
  import olp_pkg::*;

  olp_item_t in_item;
  olp_item_t held_item;
  logic      held_valid;
  logic      step_en;
  logic      rec_valid;
  olp_rec_t  rec;
  olp_rec_t  rec_out;
  logic      out_free;

  assign in_item.text_byte  = in_ch.text_byte;
  assign in_item.final_byte = in_ch.final_byte;

  assign step_en = held_valid && out_free;

  olp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_item    (in_item),
    .in_ready   (in_ch.ready),
    .step_en    (step_en),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  olp_parse #(
    .OFFSET_BITS (OFFSET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (held_item),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  olp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && rec_valid),
    .rec_in    (rec),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .rec_out   (rec_out),
    .free      (out_free)
  );

  assign out_ch.span_start       = rec_out.span_start;
  assign out_ch.span_end         = rec_out.span_end;
  assign out_ch.indent_depth     = rec_out.indent_depth;
  assign out_ch.done_mark        = rec_out.done_mark;
  assign out_ch.open_mark        = rec_out.open_mark;
  assign out_ch.placeholder_mark = rec_out.placeholder_mark;

endmodule

`default_nettype wire

/* rtl/olp_checker.sv */
// port-level checks for the outline line parser and their bind
`default_nettype none

module olp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [olp_pkg::SPAN_W-1:0]        span_start,
  input wire logic [olp_pkg::SPAN_W-1:0]        span_end,
  input wire logic [olp_pkg::DEPTH_FIELD_W-1:0] indent_depth,
  input wire logic                              done_mark,
  input wire logic                              open_mark,
  input wire logic                              placeholder_mark
);
  import olp_pkg::*;

  // a stalled record keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(span_start) && $stable(span_end)
      && $stable(indent_depth) && $stable(done_mark) && $stable(open_mark)
      && $stable(placeholder_mark))
    else $error("record changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("record valid after reset");

  // a line without a bracket group cannot be done or collapsed
  a_plain_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !placeholder_mark |-> open_mark && !done_mark)
    else $error("marks on a line with no bracket group");

  // a fresh record comes from an earlier word taken by the input register
  a_rise_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("record without a preceding input word");

endmodule

bind outline_line_parser_unit olp_checker u_olp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .span_start       (out_ch.span_start),
  .span_end         (out_ch.span_end),
  .indent_depth     (out_ch.indent_depth),
  .done_mark        (out_ch.done_mark),
  .open_mark        (out_ch.open_mark),
  .placeholder_mark (out_ch.placeholder_mark)
);

`default_nettype wire
